// ===== src/hatp_pkg.sv =====
// ----------------------------------------------------------------------------
// Hall angle tracking PLL package
// Types and constants shared by the tracking loop.
// ----------------------------------------------------------------------------
package hatp_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [1:0] REG_GAIN_NOW   = 2'd0;
  localparam logic [1:0] REG_GAIN_PREV  = 2'd1;
  localparam logic [1:0] REG_STEP_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MULT,
    ST_PI,
    ST_SAT,
    ST_OUT
  } state_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 30'd536870912;
      5'd1:  atan_turn = 30'd316933406;
      5'd2:  atan_turn = 30'd167458907;
      5'd3:  atan_turn = 30'd85004757;
      5'd4:  atan_turn = 30'd42667331;
      5'd5:  atan_turn = 30'd21354465;
      5'd6:  atan_turn = 30'd10679838;
      5'd7:  atan_turn = 30'd5340247;
      5'd8:  atan_turn = 30'd2670163;
      5'd9:  atan_turn = 30'd1335087;
      5'd10: atan_turn = 30'd667544;
      5'd11: atan_turn = 30'd333772;
      5'd12: atan_turn = 30'd166886;
      5'd13: atan_turn = 30'd83443;
      5'd14: atan_turn = 30'd41722;
      5'd15: atan_turn = 30'd20861;
      5'd16: atan_turn = 30'd10430;
      5'd17: atan_turn = 30'd5215;
      5'd18: atan_turn = 30'd2608;
      5'd19: atan_turn = 30'd1304;
      5'd20: atan_turn = 30'd652;
      5'd21: atan_turn = 30'd326;
      5'd22: atan_turn = 30'd163;
      5'd23: atan_turn = 30'd81;
      default: atan_turn = 30'd0;
    endcase
  endfunction

endpackage

// ===== src/hall_angle_tracking_pll.sv =====
// ----------------------------------------------------------------------------
// Hall angle tracking PLL
// Tracks the rotor angle from two hall samples with a CORDIC and a PI loop.
// ----------------------------------------------------------------------------
// Sequence: after a word is accepted, the CORDIC runs 24 rotations and one
// step to round and fold the quadrant, a shift-add multiply follows, then
// the PI step and the saturation step, and out_tvalid then rises.
// A new word is accepted only once the previous result has been taken, so
// the next word waits while out_tready stays low.
// Reset (rst_n low, synchronous) clears the angle, accumulator, last error
// and handshake state and restores the register defaults.
module hall_angle_tracking_pll #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hall_a [11:0], hall_b [23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // angle, cos_angle, sin_angle, a_cos_term,
                                  // b_sin_term, pi_step from bit 0 up
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_wdata
);
  import hatp_pkg::*;
  // out_tdata: angle [15:0], cos_angle [31:16], sin_angle [47:32],
  // a_cos_term [59:48], b_sin_term [71:60], pi_step [90:72], zero above.

  state_t state_r, state_nxt;
  logic [15:0] gain_now_r, gain_prev_r;
  logic [17:0] step_limit_r;
  logic [ANGLE_BITS-1:0] angle_r;
  logic signed [18:0] accum_r;
  logic signed [12:0] last_err_r;

  logic signed [11:0] a_r, b_r;
  logic signed [33:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [1:0] quad_r;
  logic [4:0] cnt_r;
  logic signed [15:0] c_r, s_r;
  // Bit-serial multipliers: the trig multiplicand shifts out one bit a cycle.
  logic [15:0] mc_r, ms_r;
  logic signed [28:0] pa_r, pb_r;
  logic signed [11:0] ac_r, bs_r;
  logic signed [33:0] delta_r;
  logic [95:0] out_r;

  logic [31:0] phase;
  logic signed [33:0] dx, dy;
  logic signed [31:0] at;
  logic signed [17:0] cr, sr;
  logic signed [15:0] cq, sq, cs, ss;
  logic signed [28:0] pa_add, pb_add;
  logic signed [29:0] ra, rb;
  logic signed [12:0] err;
  logic signed [20:0] sum, lim, neg_lim;
  logic signed [18:0] accum_sat;
  logic [ANGLE_BITS-1:0] new_angle;
  logic [15:0] angle16;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) sat16 = 16'sd32767;
    else if (v < -18'sd32768) sat16 = -16'sd32768;
    else sat16 = v[15:0];
  endfunction

  function automatic logic signed [11:0] sat12(input logic signed [29:0] v);
    logic signed [14:0] t;
    t = v[29:15];
    if (t > 15'sd2047) sat12 = 12'sd2047;
    else if (t < -15'sd2048) sat12 = -12'sd2048;
    else sat12 = t[11:0];
  endfunction

  assign phase = 32'(angle_r) << (32 - ANGLE_BITS);
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = 32'(atan_turn(cnt_r));
  assign cr = 18'((x_r + 34'sd16384) >>> 15);
  assign sr = 18'((y_r + 34'sd16384) >>> 15);

  always_comb begin
    cq = sat16(cr);
    sq = sat16(sr);
    case (quad_r)
      2'd0: begin cs = cq; ss = sq; end
      2'd1: begin cs = sat16(-18'(sq)); ss = cq; end
      2'd2: begin cs = sat16(-18'(cq)); ss = sat16(-18'(sq)); end
      default: begin cs = sq; ss = sat16(-18'(cq)); end
    endcase
  end

  // Shift-add step: bit 15 of the trig value carries negative weight.
  always_comb begin
    pa_add = (mc_r[0] ? 29'(a_r) <<< cnt_r[3:0] : 29'sd0);
    pb_add = (ms_r[0] ? 29'(b_r) <<< cnt_r[3:0] : 29'sd0);
    if (cnt_r[3:0] == 4'd15) begin
      pa_add = -pa_add;
      pb_add = -pb_add;
    end
  end

  assign ra = 30'(pa_r) + 30'sd16384;
  assign rb = 30'(pb_r) + 30'sd16384;
  assign err = 13'(ac_r) - 13'(bs_r);

  // Accumulator update and clamp to the signed step limit.
  assign sum = 21'(accum_r) + 21'(delta_r);
  assign lim = $signed({3'b000, step_limit_r});
  assign neg_lim = -lim;
  always_comb begin
    if (sum > lim) accum_sat = lim[18:0];
    else if (sum < neg_lim) accum_sat = neg_lim[18:0];
    else accum_sat = sum[18:0];
  end

  assign new_angle = angle_r + ANGLE_BITS'(accum_sat);
  always_comb begin
    angle16 = '0;
    for (int k = 0; k < 16; k++)
      if (k < ANGLE_BITS) angle16[k] = new_angle[k];
  end

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_CORDIC;
      ST_CORDIC: if (cnt_r == 5'd24) state_nxt = ST_MULT;
      ST_MULT:   if (cnt_r[3:0] == 4'd15) state_nxt = ST_PI;
      ST_PI:     state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_OUT;
      ST_OUT:    if (out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gain_now_r <= 16'd5216;
      gain_prev_r <= 16'd2608;
      step_limit_r <= 18'd104301;
      angle_r <= '0;
      accum_r <= '0;
      last_err_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_NOW:   gain_now_r <= cfg_wdata[15:0];
          REG_GAIN_PREV:  gain_prev_r <= cfg_wdata[15:0];
          REG_STEP_LIMIT: step_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: cnt_r <= '0;
        ST_CORDIC: cnt_r <= (cnt_r == 5'd24) ? 5'd0 : cnt_r + 5'd1;
        ST_MULT: cnt_r <= cnt_r + 5'd1;
        ST_SAT: begin
          accum_r <= accum_sat;
          angle_r <= new_angle;
          last_err_r <= err;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        a_r <= in_tdata[11:0];
        b_r <= in_tdata[23:12];
        quad_r <= phase[31:30];
        z_r <= {2'b00, phase[29:0]};
        x_r <= CORDIC_X0;
        y_r <= '0;
        pa_r <= '0;
        pb_r <= '0;
      end
      ST_CORDIC: begin
        // The last count only rounds and folds the finished rotation.
        if (cnt_r == 5'd24) begin
          c_r <= cs; s_r <= ss; mc_r <= cs; ms_r <= ss;
        end else if (!z_r[31]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
        end
      end
      ST_MULT: begin
        pa_r <= pa_r + pa_add;
        pb_r <= pb_r + pb_add;
        mc_r <= mc_r >> 1;
        ms_r <= ms_r >> 1;
      end
      ST_PI: begin
        ac_r <= sat12(ra);
        bs_r <= sat12(rb);
        delta_r <= 34'(($signed({1'b0, gain_now_r}) * 30'(sat12(ra) - sat12(rb)))
                   - ($signed({1'b0, gain_prev_r}) * 30'(last_err_r)) + 34'sd512) >>> 10;
      end
      ST_SAT: out_r <= {5'd0, accum_sat, bs_r, ac_r, s_r, c_r, angle16};
      default: ;
    endcase
  end

  // The result word and the new angle are both registered in ST_SAT, so the
  // word is complete when ST_OUT is entered.

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready while result pending");
  a_cordic_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORDIC && cnt_r == 5'd24) |=> state_r == ST_MULT)
    else $error("cordic length");
  a_accum_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (21'(accum_r) <= lim && 21'(accum_r) >= neg_lim))
    else $error("accumulator out of bound");
endmodule

// ===== tb/tb_hall_angle_tracking_pll.sv =====
// ----------------------------------------------------------------------------
// Hall angle tracking PLL testbench
// Drives hall sample words through the tracking loop, predicts each result
// with an independent CORDIC and PI loop model, and checks every result word
// field by field while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_hall_angle_tracking_pll;
  timeunit 1ns;
  timeprecision 1ps;

  import hatp_pkg::*;

  typedef struct {
    logic [15:0]        angle;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    logic signed [11:0] a_cos;
    logic signed [11:0] b_sin;
    logic signed [18:0] pi_step;
  } track_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // hall_a [11:0], hall_b [23:12]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;       // angle [15:0], cos_angle [31:16], sin_angle [47:32],
                                // a_cos_term [59:48], b_sin_term [71:60], pi_step [90:72]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [17:0] cfg_wdata = '0;

  hall_angle_tracking_pll dut (.*);

  // Predictor state and register copies.
  logic [15:0]        mdl_gain_now, mdl_gain_prev;
  logic [17:0]        mdl_limit;
  logic [15:0]        mdl_angle;
  longint             mdl_accum, mdl_last_err;

  track_word_t        expected_q[$];
  int                 errors = 0;
  int                 results_seen = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  initial forever #2 clk = ~clk;

  initial begin
    #20ms;
    $display("tb_hall_angle_tracking_pll NOT OK");
    $finish;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Quadrant-folded CORDIC rotation giving Q1.15 cosine and sine.
  function automatic void sincos(input logic [15:0] ang, output longint c_o,
                                 output longint s_o);
    logic [31:0] phase;
    longint      x, y, z, dx, dy, c, s;
    phase = {ang, 16'h0000};
    x = 652032874;
    y = 0;
    z = longint'(phase[29:0]);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i[4:0]));
      end
    end
    c = clip((x + 16384) >>> 15, -32768, 32767);
    s = clip((y + 16384) >>> 15, -32768, 32767);
    case (phase[31:30])
      2'd0: begin c_o = c;  s_o = s;  end
      2'd1: begin c_o = -s; s_o = c;  end
      2'd2: begin c_o = -c; s_o = -s; end
      default: begin c_o = s; s_o = -c; end
    endcase
    c_o = clip(c_o, -32768, 32767);
    s_o = clip(s_o, -32768, 32767);
  endfunction

  function automatic track_word_t track_step(logic signed [11:0] a, logic signed [11:0] b);
    track_word_t r;
    longint      c, s, ac, bs, err, delta, lim;
    sincos(mdl_angle, c, s);
    ac = clip((longint'(a) * c + 16384) >>> 15, -2048, 2047);
    bs = clip((longint'(b) * s + 16384) >>> 15, -2048, 2047);
    err = ac - bs;
    delta = (longint'(mdl_gain_now) * err - longint'(mdl_gain_prev) * mdl_last_err + 512)
            >>> 10;
    lim = longint'(mdl_limit);
    mdl_accum = clip(mdl_accum + delta, -lim, lim);
    mdl_last_err = err;
    mdl_angle = mdl_angle + mdl_accum[15:0];
    r.angle = mdl_angle;
    r.cos_v = c[15:0];
    r.sin_v = s[15:0];
    r.a_cos = ac[11:0];
    r.b_sin = bs[11:0];
    r.pi_step = mdl_accum[18:0];
    return r;
  endfunction

  // Predict at the accepting edge of each input word.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_q.push_back(track_step(in_tdata[11:0], in_tdata[23:12]));
  end

  always @(posedge clk) begin
    track_word_t got, exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      got.angle   = out_tdata[15:0];
      got.cos_v   = out_tdata[31:16];
      got.sin_v   = out_tdata[47:32];
      got.a_cos   = out_tdata[59:48];
      got.b_sin   = out_tdata[71:60];
      got.pi_step = out_tdata[90:72];
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word angle=%0d", got.angle);
      end else begin
        exp_w = expected_q.pop_front();
        if (got.angle !== exp_w.angle || got.cos_v !== exp_w.cos_v ||
            got.sin_v !== exp_w.sin_v || got.a_cos !== exp_w.a_cos ||
            got.b_sin !== exp_w.b_sin || got.pi_step !== exp_w.pi_step) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp ang=%0d cos=%0d sin=%0d ac=%0d bs=%0d pi=%0d | ",
                     exp_w.angle, exp_w.cos_v, exp_w.sin_v, exp_w.a_cos, exp_w.b_sin,
                     exp_w.pi_step, "got ang=%0d cos=%0d sin=%0d ac=%0d bs=%0d pi=%0d",
                     got.angle, got.cos_v, got.sin_v, got.a_cos, got.b_sin, got.pi_step);
        end
      end
    end
  end

  // Receiver backpressure.
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_word(logic signed [11:0] a, logic signed [11:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {b, a};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Waits for all results plus the loop latency so the block is idle.
  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_GAIN_NOW:   mdl_gain_now = val[15:0];
      REG_GAIN_PREV:  mdl_gain_prev = val[15:0];
      REG_STEP_LIMIT: mdl_limit = val;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    logic signed [11:0] ext[3] = '{-12'sd2048, 12'sd0, 12'sd2047};
    // Angle zero gives a full-scale cosine; extreme samples overflow products.
    foreach (ext[i]) foreach (ext[j]) send_word(ext[i], ext[j]);
    drain();
    // Zero limit pins the PI output; an out-of-range index must be ignored.
    write_reg(REG_STEP_LIMIT, 18'd0);
    write_reg(2'd3, 18'h3FFFF);
    repeat (3) send_word(12'sd2047, -12'sd2048);
    drain();
    // Maximum current gain, zero previous gain and maximum limit spin the angle through wraps both ways.
    write_reg(REG_GAIN_NOW, 18'hFFFF);
    write_reg(REG_GAIN_PREV, 18'd0);
    write_reg(REG_STEP_LIMIT, 18'h3FFFF);
    repeat (4) send_word(12'sd2047, -12'sd2048);
    repeat (4) send_word(-12'sd2048, 12'sd2047);
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    case ($urandom_range(3))
      0: begin
        write_reg(REG_GAIN_NOW, 18'd5216);
        write_reg(REG_GAIN_PREV, 18'd2608);
        write_reg(REG_STEP_LIMIT, 18'd104301);
      end
      1: begin
        write_reg(REG_GAIN_NOW, 18'($urandom_range(65535)));
        write_reg(REG_GAIN_PREV, 18'($urandom_range(65535)));
        write_reg(REG_STEP_LIMIT, 18'($urandom_range(262143)));
      end
      2: begin
        write_reg(REG_GAIN_NOW, 18'($urandom_range(8000)));
        write_reg(REG_GAIN_PREV, 18'($urandom_range(4000)));
        write_reg(REG_STEP_LIMIT, 18'($urandom_range(4000)));
      end
      default: begin
        write_reg(REG_GAIN_NOW, 18'($urandom_range(1) ? 65535 : 0));
        write_reg(REG_GAIN_PREV, 18'($urandom_range(1) ? 65535 : 0));
        write_reg(REG_STEP_LIMIT, 18'($urandom_range(1) ? 262143 : 0));
      end
    endcase
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      send_word(12'($urandom()), 12'($urandom()));
    end
    drain();
  endtask

  initial begin
    mdl_gain_now = 16'd5216;
    mdl_gain_prev = 16'd2608;
    mdl_limit = 18'd104301;
    mdl_angle = '0;
    mdl_accum = 0;
    mdl_last_err = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    for (int p = 0; p < 2; p++) begin
      test_random(230, 0, 0);
      test_random(230, 66, 0);
      test_random(230, 0, 66);
      test_random(230, 19, 19);
    end
    drain();
    $display("Covered %0d result words across register extremes, saturation and wraps,",
             results_seen);
    $display("with sender gaps and receiver stalls in separate and mixed phases.");
    if (errors == 0 && expected_q.size() == 0)
      $display("tb_hall_angle_tracking_pll OK");
    else
      $display("tb_hall_angle_tracking_pll NOT OK");
    $finish;
  end

endmodule
